>>> sv/sdsh_pkg.sv
`timescale 1ns / 1ps
// Package for the SD card SPI host sequencer: item types, register map,
// sequencer phases and protocol constants. No dependencies.
package sdsh_pkg;

    localparam int BLOCK_BYTES  = 512;
    localparam int DUMMY_BYTES  = 20;
    localparam int WAKE_BYTES   = 10;
    localparam int ADDR_W       = 5;

    localparam logic [15:0] INIT_TIMEOUT_RST  = 16'd2000;
    localparam logic [15:0] TOKEN_TIMEOUT_RST = 16'd500;
    localparam logic [3:0]  RESET_ATT_RST     = 4'd5;
    localparam logic [3:0]  READ_ATT_RST      = 4'd3;
    localparam logic [3:0]  POLL_BYTES_RST    = 4'd8;

    typedef enum logic [2:0] {
        REG_INIT_TIMEOUT  = 3'd0,
        REG_TOKEN_TIMEOUT = 3'd1,
        REG_RESET_ATT     = 3'd2,
        REG_READ_ATT      = 3'd3,
        REG_POLL_BYTES    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_READ  = 2'd1,
        OP_BYTE  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOCARD = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_SDV1    = 3'd1;
    localparam logic [2:0] KIND_SDV2    = 3'd2;
    localparam logic [2:0] KIND_SDHC    = 3'd3;
    localparam logic [2:0] KIND_MMC     = 3'd4;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SEND_OP   = 6'd1;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
    localparam logic [5:0] CMD_READ_ONE  = 6'd17;
    localparam logic [5:0] CMD_SD_OP     = 6'd41;
    localparam logic [5:0] CMD_APP       = 6'd55;
    localparam logic [5:0] CMD_READ_OCR  = 6'd58;
    localparam logic [5:0] CMD_CRC_ON    = 6'd59;

    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
    localparam logic [7:0]  BYTE_IDLE   = 8'hFF;
    localparam logic [7:0]  BYTE_TOKEN  = 8'hFE;
    localparam logic [7:0]  BYTE_CHECK  = 8'hAA;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [7:0]  R1_READY    = 8'h00;

    typedef enum logic [11:0] {
        PH_IDLE  = 12'b0000_0000_0001,
        PH_DUMMY = 12'b0000_0000_0010,
        PH_WAKE  = 12'b0000_0000_0100,
        PH_CMD   = 12'b0000_0000_1000,
        PH_POLL  = 12'b0000_0001_0000,
        PH_R7    = 12'b0000_0010_0000,
        PH_OCR   = 12'b0000_0100_0000,
        PH_GAP   = 12'b0000_1000_0000,
        PH_TOKEN = 12'b0001_0000_0000,
        PH_DATA  = 12'b0010_0000_0000,
        PH_CRC   = 12'b0100_0000_0000,
        PH_LAST  = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] init_timeout_ms;
        logic [15:0] token_timeout_ms;
        logic [3:0]  reset_attempts;
        logic [3:0]  read_attempts;
        logic [3:0]  response_poll_bytes;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] block_number;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        select_low;
        logic        fast_clock;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        done_res;
        logic [1:0]  status;
        logic [2:0]  card_kind;
    } out_item_t;

    function automatic logic [3:0] at_least_one(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

endpackage

>>> sv/sd_card_spi_host_sequencer.sv
`timescale 1ns / 1ps
// SD card SPI-mode host sequencer top level: input register, sequencer
// core, result register and APB registers. Depends on sdsh_pkg, sdsh_cfg, sdsh_core.
//
// Each item (start init, start read, received byte, millisecond tick) is
// captured in an input register and processed by the sequencer core when
// the output register is free or being emptied; the core's result goes to
// an output register. A new item is accepted every cycle while results are
// taken. Ticks give no result, nor do bytes received while idle.
module sd_card_spi_host_sequencer
    import sdsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  in_item_t          req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output out_item_t         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t      cfg;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      res_valid;
    out_item_t res;
    logic      step;

    sdsh_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdsh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .item      (in_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign step      = in_valid_reg && (!res_valid || !out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || step;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (step && res_valid)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_reg <= req;
        if (step && res_valid)
            out_reg <= res;
    end

endmodule

>>> sv/sdsh_cfg.sv
`timescale 1ns / 1ps
// APB register file for the sequencer timeouts and retry limits.
// Depends on sdsh_pkg.
module sdsh_cfg
    import sdsh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_timeout_ms     <= INIT_TIMEOUT_RST;
            cfg_reg.token_timeout_ms    <= TOKEN_TIMEOUT_RST;
            cfg_reg.reset_attempts      <= RESET_ATT_RST;
            cfg_reg.read_attempts       <= READ_ATT_RST;
            cfg_reg.response_poll_bytes <= POLL_BYTES_RST;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (idx)
                REG_INIT_TIMEOUT:  cfg_reg.init_timeout_ms     <= pwdata[15:0];
                REG_TOKEN_TIMEOUT: cfg_reg.token_timeout_ms    <= pwdata[15:0];
                REG_RESET_ATT:     cfg_reg.reset_attempts      <= pwdata[3:0];
                REG_READ_ATT:      cfg_reg.read_attempts       <= pwdata[3:0];
                REG_POLL_BYTES:    cfg_reg.response_poll_bytes <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            REG_INIT_TIMEOUT:  prdata = {16'd0, cfg_reg.init_timeout_ms};
            REG_TOKEN_TIMEOUT: prdata = {16'd0, cfg_reg.token_timeout_ms};
            REG_RESET_ATT:     prdata = {28'd0, cfg_reg.reset_attempts};
            REG_READ_ATT:      prdata = {28'd0, cfg_reg.read_attempts};
            REG_POLL_BYTES:    prdata = {28'd0, cfg_reg.response_poll_bytes};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

>>> sv/sdsh_core.sv
`timescale 1ns / 1ps
// Sequencer state and next-step logic: one item in, at most one result out.
// Depends on sdsh_pkg.
module sdsh_core
    import sdsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res
);

    phase_t      phase_reg, phase_next;
    logic [9:0]  bc_reg, bc_next;
    logic [3:0]  att_reg, att_next;
    logic [3:0]  poll_reg, poll_next;
    logic [47:0] frame_reg, frame_next;
    logic [15:0] ms_reg, ms_next;
    logic [31:0] tail_reg, tail_next;
    logic [7:0]  last_reg, last_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] addr_reg, addr_next;
    logic        fast_reg, fast_next;

    always_comb
    begin
        logic        send, fin, begin_cmd, gap;
        logic [7:0]  tx;
        logic        sel, dv;
        logic [7:0]  db;
        logic [1:0]  st;
        logic [5:0]  ncmd;
        logic [31:0] narg;
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  r;
        logic [7:0]  crc;

        phase_next = phase_reg;
        bc_next    = bc_reg;
        att_next   = att_reg;
        poll_next  = poll_reg;
        frame_next = frame_reg;
        ms_next    = ms_reg;
        tail_next  = tail_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        fast_next  = fast_reg;

        send = 1'b0;  fin = 1'b0;  begin_cmd = 1'b0;  gap = 1'b0;
        tx = BYTE_IDLE;  sel = 1'b0;  dv = 1'b0;  db = 8'd0;  st = ST_OK;
        ncmd = CMD_GO_IDLE;  narg = 32'd0;  crc = 8'h01;
        cmd = frame_reg[45:40];
        arg = frame_reg[39:8];
        r   = last_reg;

        case (op_t'(item.operation))
            OP_INIT:
            begin
                kind_next  = KIND_UNKNOWN;
                fast_next  = 1'b0;
                att_next   = 4'd0;
                bc_next    = 10'd0;
                phase_next = PH_DUMMY;
                send = 1'b1;
            end
            OP_READ:
            begin
                addr_next = (kind_reg == KIND_SDHC) ? item.block_number
                                                    : {item.block_number[22:0], 9'd0};
                att_next  = 4'd0;
                begin_cmd = 1'b1;  ncmd = CMD_READ_ONE;  narg = addr_next;
            end
            OP_TICK:
            begin
                if (ms_reg != 16'd0)
                    ms_next = ms_reg - 16'd1;
            end
            default:
            begin
                unique case (phase_reg)
                    PH_DUMMY:
                    begin
                        bc_next = bc_reg + 10'd1;
                        send = 1'b1;
                        if (bc_next >= 10'(DUMMY_BYTES))
                        begin
                            phase_next = PH_WAKE;
                            bc_next    = 10'd0;
                        end
                    end
                    PH_WAKE:
                    begin
                        bc_next = bc_reg + 10'd1;
                        if (bc_next < 10'(WAKE_BYTES))
                            send = 1'b1;
                        else
                        begin
                            begin_cmd = 1'b1;  ncmd = CMD_GO_IDLE;  narg = 32'd0;
                        end
                    end
                    PH_CMD:
                    begin
                        bc_next = bc_reg + 10'd1;
                        send = 1'b1;
                        sel  = 1'b1;
                        case (bc_next[2:0])
                            3'd1:    tx = frame_reg[39:32];
                            3'd2:    tx = frame_reg[31:24];
                            3'd3:    tx = frame_reg[23:16];
                            3'd4:    tx = frame_reg[15:8];
                            3'd5:    tx = frame_reg[7:0];
                            default: tx = BYTE_IDLE;
                        endcase
                        if (bc_next >= 10'd6)
                        begin
                            phase_next = PH_POLL;
                            poll_next  = 4'd0;
                        end
                    end
                    PH_POLL:
                    begin
                        poll_next = poll_reg + 4'd1;
                        if (!item.rx_byte[7] ||
                            poll_next >= at_least_one(cfg.response_poll_bytes))
                        begin
                            last_next = item.rx_byte;
                            bc_next   = 10'd0;
                            if (cmd == CMD_IF_COND || cmd == CMD_READ_OCR)
                                tail_next = 32'd0;
                            if (cmd == CMD_IF_COND && item.rx_byte == R1_IDLE)
                            begin
                                phase_next = PH_R7;  send = 1'b1;  sel = 1'b1;
                            end
                            else if (cmd == CMD_READ_OCR && item.rx_byte == R1_READY)
                            begin
                                phase_next = PH_OCR;  send = 1'b1;  sel = 1'b1;
                            end
                            else if (cmd == CMD_READ_ONE && item.rx_byte == R1_READY)
                            begin
                                ms_next    = cfg.token_timeout_ms;
                                phase_next = PH_TOKEN;  send = 1'b1;  sel = 1'b1;
                            end
                            else
                                gap = 1'b1;
                        end
                        else
                        begin
                            send = 1'b1;  sel = 1'b1;
                        end
                    end
                    PH_R7, PH_OCR:
                    begin
                        tail_next = {tail_reg[23:0], item.rx_byte};
                        bc_next   = bc_reg + 10'd1;
                        if (bc_next < 10'd4)
                        begin
                            send = 1'b1;  sel = 1'b1;
                        end
                        else
                        begin
                            if (phase_reg == PH_OCR)
                                kind_next = tail_next[30] ? KIND_SDHC : KIND_SDV2;
                            gap = 1'b1;
                        end
                    end
                    PH_GAP:
                    begin
                        case (cmd)
                            CMD_GO_IDLE:
                            begin
                                att_next = att_reg + 4'd1;
                                if (r == R1_IDLE)
                                begin
                                    begin_cmd = 1'b1;  ncmd = CMD_IF_COND;
                                    narg = ARG_IF_COND;
                                end
                                else if (att_next >= at_least_one(cfg.reset_attempts))
                                begin
                                    fin = 1'b1;  st = ST_NOCARD;
                                end
                                else
                                begin
                                    phase_next = PH_WAKE;
                                    bc_next    = 10'd0;
                                    send = 1'b1;
                                end
                            end
                            CMD_IF_COND:
                            begin
                                ms_next = cfg.init_timeout_ms;
                                if (r == R1_IDLE && tail_reg[7:0] != BYTE_CHECK)
                                begin
                                    fin = 1'b1;  st = ST_ERROR;
                                end
                                else
                                begin
                                    att_next  = (r == R1_IDLE) ? 4'd1 : 4'd0;
                                    begin_cmd = 1'b1;  ncmd = CMD_APP;  narg = 32'd0;
                                end
                            end
                            CMD_APP:
                            begin
                                begin_cmd = 1'b1;  ncmd = CMD_SD_OP;
                                narg = (att_reg != 4'd0) ? ARG_HCS : 32'd0;
                            end
                            CMD_SD_OP:
                            begin
                                if (r == R1_IDLE && ms_reg != 16'd0)
                                begin
                                    begin_cmd = 1'b1;  ncmd = CMD_APP;  narg = 32'd0;
                                end
                                else if (r == R1_READY)
                                begin
                                    begin_cmd = 1'b1;
                                    if (arg == ARG_HCS)
                                    begin
                                        ncmd = CMD_READ_OCR;  narg = 32'd0;
                                    end
                                    else
                                    begin
                                        kind_next = KIND_SDV1;
                                        ncmd = CMD_BLOCKLEN;  narg = 32'(BLOCK_BYTES);
                                    end
                                end
                                else if (arg == ARG_HCS)
                                begin
                                    fin = 1'b1;  st = ST_ERROR;
                                end
                                else
                                begin
                                    ms_next   = cfg.init_timeout_ms;
                                    begin_cmd = 1'b1;  ncmd = CMD_SEND_OP;  narg = 32'd0;
                                end
                            end
                            CMD_SEND_OP:
                            begin
                                if (r == R1_IDLE && ms_reg != 16'd0)
                                begin
                                    begin_cmd = 1'b1;  ncmd = CMD_SEND_OP;  narg = 32'd0;
                                end
                                else if (r != R1_READY)
                                begin
                                    fin = 1'b1;  st = ST_ERROR;
                                end
                                else
                                begin
                                    kind_next = KIND_MMC;
                                    begin_cmd = 1'b1;  ncmd = CMD_BLOCKLEN;
                                    narg = 32'(BLOCK_BYTES);
                                end
                            end
                            CMD_READ_OCR:
                            begin
                                begin_cmd = 1'b1;  ncmd = CMD_CRC_ON;  narg = 32'd0;
                            end
                            CMD_BLOCKLEN:
                            begin
                                if (r != R1_READY)
                                begin
                                    fin = 1'b1;  st = ST_ERROR;
                                end
                                else
                                begin
                                    begin_cmd = 1'b1;  ncmd = CMD_CRC_ON;  narg = 32'd0;
                                end
                            end
                            CMD_CRC_ON:
                            begin
                                fast_next = 1'b1;
                                fin = 1'b1;  st = ST_OK;
                            end
                            CMD_READ_ONE:
                            begin
                                att_next = att_reg + 4'd1;
                                if (att_next >= at_least_one(cfg.read_attempts))
                                begin
                                    fin = 1'b1;  st = ST_ERROR;
                                end
                                else
                                begin
                                    begin_cmd = 1'b1;  ncmd = CMD_READ_ONE;
                                    narg = addr_reg;
                                end
                            end
                            default:
                            begin
                                fin = 1'b1;  st = ST_ERROR;
                            end
                        endcase
                    end
                    PH_TOKEN:
                    begin
                        if (item.rx_byte == BYTE_IDLE && ms_reg != 16'd0)
                        begin
                            send = 1'b1;  sel = 1'b1;
                        end
                        else if (item.rx_byte == BYTE_TOKEN)
                        begin
                            phase_next = PH_DATA;
                            bc_next    = 10'd0;
                            send = 1'b1;  sel = 1'b1;
                        end
                        else
                        begin
                            last_next = item.rx_byte;
                            gap = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        {phase_next, bc_next} = {phase_reg, bc_reg + 10'd1};
                        if (bc_reg == 10'(BLOCK_BYTES - 1))
                        begin
                            phase_next = PH_CRC;
                            bc_next    = 10'd0;
                        end
                        send = 1'b1;  sel = 1'b1;  dv = 1'b1;  db = item.rx_byte;
                    end
                    PH_CRC:
                    begin
                        bc_next = bc_reg + 10'd1;
                        send = 1'b1;
                        sel  = (bc_next < 10'd2);
                        if (bc_next >= 10'd2)
                            phase_next = PH_LAST;
                    end
                    PH_LAST:
                    begin
                        fin = 1'b1;  st = ST_OK;
                    end
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        endcase

        if (gap)
        begin
            phase_next = PH_GAP;
            send = 1'b1;  sel = 1'b0;  tx = BYTE_IDLE;
        end

        if (begin_cmd)
        begin
            if (ncmd == CMD_GO_IDLE)
                crc = 8'h95;
            else if (ncmd == CMD_IF_COND)
                crc = 8'h87;
            else
                crc = 8'h01;
            frame_next = {2'b01, ncmd, narg, crc};
            phase_next = PH_CMD;
            bc_next    = 10'd0;
            poll_next  = 4'd0;
            send = 1'b1;  sel = 1'b1;  tx = frame_next[47:40];
        end

        if (fin)
            phase_next = PH_IDLE;

        res_valid = send || fin;
        res.tx_valid   = send;
        res.tx_byte    = fin ? BYTE_IDLE : tx;
        res.select_low = fin ? 1'b0 : sel;
        res.fast_clock = fast_next;
        res.data_valid = dv;
        res.data_byte  = db;
        res.done_res   = fin;
        res.status     = fin ? st : ST_OK;
        res.card_kind  = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bc_reg    <= 10'd0;
            att_reg   <= 4'd0;
            poll_reg  <= 4'd0;
            frame_reg <= 48'd0;
            ms_reg    <= 16'd0;
            tail_reg  <= 32'd0;
            last_reg  <= BYTE_IDLE;
            kind_reg  <= KIND_UNKNOWN;
            addr_reg  <= 32'd0;
            fast_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bc_reg    <= bc_next;
            att_reg   <= att_next;
            poll_reg  <= poll_next;
            frame_reg <= frame_next;
            ms_reg    <= ms_next;
            tail_reg  <= tail_next;
            last_reg  <= last_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
            fast_reg  <= fast_next;
        end
    end

endmodule

>>> tb/sd_card_spi_host_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sd_card_spi_host_sequencer: a scripted SD card
// answers the predicted exchanges; results are checked against an in-bench
// model of the sequencer. Depends on sdsh_pkg and the sequencer RTL.
module sd_card_spi_host_sequencer_tb;
    import sdsh_pkg::*;

    typedef enum int {
        CARD_HC, CARD_V2, CARD_V1, CARD_MMC, CARD_NONE, CARD_BAD_R7
    } card_profile_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    in_item_t          req = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    out_item_t         rsp;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    sd_card_spi_host_sequencer u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sequencer model state
    cfg_t        cfg_m;
    phase_t      seq_phase;
    logic [9:0]  xfer_count;
    logic [3:0]  try_count;
    logic [3:0]  poll_seen;
    logic [47:0] cmd_frame;
    logic [15:0] ms_left;
    logic [31:0] reply_word;
    logic [7:0]  last_r1;
    logic [2:0]  model_kind;
    logic [31:0] read_addr;
    logic        fast_sel;
    bit          has_result;

    out_item_t   expected_q[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          sessions = 0;
    int          cfg_sets = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;
    int          pat_cnt = 0;
    int          stall_mode = 0;
    card_profile_t profile = CARD_HC;

    function automatic logic [3:0] min_one(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

    function automatic out_item_t mk(input logic txv, input logic [7:0] tx, input logic sel,
                                     input logic dv, input logic [7:0] db, input logic done,
                                     input logic [1:0] st);
        out_item_t r;
        r.tx_valid = txv;
        r.tx_byte = tx;
        r.select_low = sel;
        r.fast_clock = fast_sel;
        r.data_valid = dv;
        r.data_byte = db;
        r.done_res = done;
        r.status = st;
        r.card_kind = model_kind;
        has_result = 1'b1;
        return r;
    endfunction

    function automatic out_item_t tx_out(input logic [7:0] tx, input logic sel);
        return mk(1'b1, tx, sel, 1'b0, 8'h00, 1'b0, ST_OK);
    endfunction

    function automatic out_item_t finish_op(input logic [1:0] st);
        seq_phase = PH_IDLE;
        return mk(1'b0, BYTE_IDLE, 1'b0, 1'b0, 8'h00, 1'b1, st);
    endfunction

    function automatic logic [5:0] frame_cmd();
        return cmd_frame[45:40];
    endfunction

    function automatic out_item_t issue_cmd(input logic [5:0] cmd, input logic [31:0] arg);
        logic [7:0] crc;
        crc = 8'h01;
        if (cmd == CMD_GO_IDLE) crc = 8'h95;
        if (cmd == CMD_IF_COND) crc = 8'h87;
        cmd_frame = {2'b01, cmd, arg, crc};
        seq_phase = PH_CMD;
        xfer_count = '0;
        poll_seen = '0;
        return tx_out(cmd_frame[47:40], 1'b1);
    endfunction

    function automatic out_item_t gap_byte();
        seq_phase = PH_GAP;
        return tx_out(BYTE_IDLE, 1'b0);
    endfunction

    function automatic out_item_t got_r1(input logic [7:0] r);
        logic [5:0] cmd;
        cmd = frame_cmd();
        last_r1 = r;
        xfer_count = '0;
        if (cmd == CMD_IF_COND || cmd == CMD_READ_OCR) reply_word = '0;
        if (cmd == CMD_IF_COND && r == R1_IDLE)
        begin
            seq_phase = PH_R7;
            return tx_out(BYTE_IDLE, 1'b1);
        end
        if (cmd == CMD_READ_OCR && r == R1_READY)
        begin
            seq_phase = PH_OCR;
            return tx_out(BYTE_IDLE, 1'b1);
        end
        if (cmd == CMD_READ_ONE && r == R1_READY)
        begin
            ms_left = cfg_m.token_timeout_ms;
            seq_phase = PH_TOKEN;
            return tx_out(BYTE_IDLE, 1'b1);
        end
        return gap_byte();
    endfunction

    function automatic out_item_t next_cmd();
        logic [7:0] r;
        r = last_r1;
        case (frame_cmd())
            CMD_GO_IDLE:
            begin
                try_count = try_count + 4'd1;
                if (r == R1_IDLE) return issue_cmd(CMD_IF_COND, ARG_IF_COND);
                if (try_count >= min_one(cfg_m.reset_attempts)) return finish_op(ST_NOCARD);
                seq_phase = PH_WAKE;
                xfer_count = '0;
                return tx_out(BYTE_IDLE, 1'b0);
            end
            CMD_IF_COND:
            begin
                ms_left = cfg_m.init_timeout_ms;
                if (r == R1_IDLE)
                begin
                    if (reply_word[7:0] != BYTE_CHECK) return finish_op(ST_ERROR);
                    try_count = 4'd1;
                end
                else
                    try_count = 4'd0;
                return issue_cmd(CMD_APP, 32'd0);
            end
            CMD_APP:
                return issue_cmd(CMD_SD_OP, (try_count != 0) ? ARG_HCS : 32'd0);
            CMD_SD_OP:
            begin
                if (r == R1_IDLE && ms_left != 0) return issue_cmd(CMD_APP, 32'd0);
                if (r == R1_READY)
                begin
                    if (cmd_frame[39:8] == ARG_HCS) return issue_cmd(CMD_READ_OCR, 32'd0);
                    model_kind = KIND_SDV1;
                    return issue_cmd(CMD_BLOCKLEN, BLOCK_BYTES);
                end
                if (cmd_frame[39:8] == ARG_HCS) return finish_op(ST_ERROR);
                ms_left = cfg_m.init_timeout_ms;
                return issue_cmd(CMD_SEND_OP, 32'd0);
            end
            CMD_SEND_OP:
            begin
                if (r == R1_IDLE && ms_left != 0) return issue_cmd(CMD_SEND_OP, 32'd0);
                if (r != R1_READY) return finish_op(ST_ERROR);
                model_kind = KIND_MMC;
                return issue_cmd(CMD_BLOCKLEN, BLOCK_BYTES);
            end
            CMD_READ_OCR:
                return issue_cmd(CMD_CRC_ON, 32'd0);
            CMD_BLOCKLEN:
            begin
                if (r != R1_READY) return finish_op(ST_ERROR);
                return issue_cmd(CMD_CRC_ON, 32'd0);
            end
            CMD_CRC_ON:
            begin
                fast_sel = 1'b1;
                return finish_op(ST_OK);
            end
            CMD_READ_ONE:
            begin
                try_count = try_count + 4'd1;
                if (try_count >= min_one(cfg_m.read_attempts)) return finish_op(ST_ERROR);
                return issue_cmd(CMD_READ_ONE, read_addr);
            end
            default:
                return finish_op(ST_ERROR);
        endcase
    endfunction

    function automatic out_item_t byte_in(input logic [7:0] rx);
        out_item_t none;
        none = '0;
        case (seq_phase)
            PH_DUMMY:
            begin
                xfer_count++;
                if (xfer_count < DUMMY_BYTES) return tx_out(BYTE_IDLE, 1'b0);
                seq_phase = PH_WAKE;
                xfer_count = '0;
                return tx_out(BYTE_IDLE, 1'b0);
            end
            PH_WAKE:
            begin
                xfer_count++;
                if (xfer_count < WAKE_BYTES) return tx_out(BYTE_IDLE, 1'b0);
                return issue_cmd(CMD_GO_IDLE, 32'd0);
            end
            PH_CMD:
            begin
                xfer_count++;
                if (xfer_count < 6)
                    return tx_out(8'(cmd_frame >> (40 - 8 * xfer_count)), 1'b1);
                seq_phase = PH_POLL;
                poll_seen = '0;
                return tx_out(BYTE_IDLE, 1'b1);
            end
            PH_POLL:
            begin
                poll_seen = poll_seen + 4'd1;
                if (!rx[7] || poll_seen >= min_one(cfg_m.response_poll_bytes))
                    return got_r1(rx);
                return tx_out(BYTE_IDLE, 1'b1);
            end
            PH_R7, PH_OCR:
            begin
                reply_word = {reply_word[23:0], rx};
                xfer_count++;
                if (xfer_count < 4) return tx_out(BYTE_IDLE, 1'b1);
                if (seq_phase == PH_OCR) model_kind = reply_word[30] ? KIND_SDHC : KIND_SDV2;
                return gap_byte();
            end
            PH_GAP:
                return next_cmd();
            PH_TOKEN:
            begin
                if (rx == BYTE_IDLE && ms_left != 0) return tx_out(BYTE_IDLE, 1'b1);
                if (rx == BYTE_TOKEN)
                begin
                    seq_phase = PH_DATA;
                    xfer_count = '0;
                    return tx_out(BYTE_IDLE, 1'b1);
                end
                last_r1 = rx;
                return gap_byte();
            end
            PH_DATA:
            begin
                xfer_count++;
                if (xfer_count >= BLOCK_BYTES)
                begin
                    seq_phase = PH_CRC;
                    xfer_count = '0;
                end
                return mk(1'b1, BYTE_IDLE, 1'b1, 1'b1, rx, 1'b0, ST_OK);
            end
            PH_CRC:
            begin
                xfer_count++;
                if (xfer_count < 2) return tx_out(BYTE_IDLE, 1'b1);
                seq_phase = PH_LAST;
                return tx_out(BYTE_IDLE, 1'b0);
            end
            PH_LAST:
                return finish_op(ST_OK);
            default:
            begin
                seq_phase = PH_IDLE;
                return none;
            end
        endcase
    endfunction

    function automatic out_item_t sequencer_step(input in_item_t it);
        out_item_t none;
        none = '0;
        has_result = 1'b0;
        case (op_t'(it.operation))
            OP_INIT:
            begin
                model_kind = KIND_UNKNOWN;
                fast_sel = 1'b0;
                try_count = '0;
                xfer_count = '0;
                seq_phase = PH_DUMMY;
                return tx_out(BYTE_IDLE, 1'b0);
            end
            OP_READ:
            begin
                read_addr = (model_kind == KIND_SDHC) ? it.block_number
                                                      : it.block_number * BLOCK_BYTES;
                try_count = '0;
                return issue_cmd(CMD_READ_ONE, read_addr);
            end
            OP_TICK:
            begin
                if (ms_left != 0) ms_left--;
                return none;
            end
            default:
                return byte_in(it.rx_byte);
        endcase
    endfunction

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_err($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_err("result with nothing expected");
            else
            begin
                want = expected_q.pop_front();
                check_field("tx_valid", rsp.tx_valid, want.tx_valid);
                check_field("tx_byte", rsp.tx_byte, want.tx_byte);
                check_field("select_low", rsp.select_low, want.select_low);
                check_field("fast_clock", rsp.fast_clock, want.fast_clock);
                check_field("data_valid", rsp.data_valid, want.data_valid);
                check_field("data_byte", rsp.data_byte, want.data_byte);
                check_field("done_res", rsp.done_res, want.done_res);
                check_field("status", rsp.status, want.status);
                check_field("card_kind", rsp.card_kind, want.card_kind);
            end
        end
    end

    // receiver: long hold-off on request, otherwise a randomly switched stall pattern
    always @(posedge clk)
    begin
        pat_cnt++;
        if (pat_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
        if (hold_req)
        begin
            rsp_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= 400)
            begin
                hold_cnt = 0;
                hold_req = 1'b0;
            end
        end
        else
            case (stall_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= $urandom_range(0, 1);
                2: rsp_ready <= (pat_cnt % 4 == 0);
                default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
    end

    task automatic send_item(input in_item_t it);
        out_item_t r;
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        r = sequencer_step(it);
        if (has_result) expected_q.push_back(r);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if (gaps_on)
            begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_INIT_TIMEOUT:  cfg_m.init_timeout_ms = v[15:0];
            REG_TOKEN_TIMEOUT: cfg_m.token_timeout_ms = v[15:0];
            REG_RESET_ATT:     cfg_m.reset_attempts = v[3:0];
            REG_READ_ATT:      cfg_m.read_attempts = v[3:0];
            default:           cfg_m.response_poll_bytes = v[3:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] init_ms, input logic [15:0] tok_ms,
                              input logic [3:0] rst_att, input logic [3:0] rd_att,
                              input logic [3:0] polls);
        drain();
        apb_write(REG_INIT_TIMEOUT, {16'($urandom_range(0, 65535)), init_ms});
        apb_write(REG_TOKEN_TIMEOUT, {16'h0, tok_ms});
        apb_write(REG_RESET_ATT, {28'h0, rst_att});
        apb_write(REG_READ_ATT, {28'h0, rd_att});
        apb_write(REG_POLL_BYTES, {28'h0, polls});
        cfg_sets++;
    endtask

    function automatic logic [7:0] card_byte();
        int p;
        p = $urandom_range(0, 99);
        case (seq_phase)
            PH_POLL:
            begin
                if (p < 25) return {1'b1, 7'($urandom)};
                case (frame_cmd())
                    CMD_GO_IDLE:
                        return (profile == CARD_NONE) ? BYTE_IDLE : (p < 35 ? 8'h05 : R1_IDLE);
                    CMD_IF_COND:
                        return (profile inside {CARD_HC, CARD_V2, CARD_BAD_R7}) ? R1_IDLE : 8'h05;
                    CMD_APP:
                        return R1_IDLE;
                    CMD_SD_OP:
                        return (profile == CARD_MMC) ? 8'h05 : (p < 65 ? R1_IDLE : R1_READY);
                    CMD_SEND_OP:
                        return p < 60 ? R1_IDLE : (p < 95 ? R1_READY : 8'h04);
                    CMD_READ_OCR, CMD_BLOCKLEN, CMD_READ_ONE:
                        return p < 88 ? R1_READY : 8'h04;
                    default:
                        return R1_READY;
                endcase
            end
            PH_R7:
                if (xfer_count == 3) return (profile == CARD_BAD_R7) ? 8'h55 : BYTE_CHECK;
                else return (xfer_count == 2) ? 8'h01 : 8'h00;
            PH_OCR:
                if (xfer_count == 0) return (profile == CARD_HC) ? 8'hC0 : 8'h80;
                else return 8'($urandom);
            PH_TOKEN:
                return p < 70 ? BYTE_IDLE : (p < 93 ? BYTE_TOKEN : 8'($urandom));
            default:
                return 8'($urandom);
        endcase
    endfunction

    function automatic in_item_t card_item();
        in_item_t it;
        bit timed;
        it.operation = OP_BYTE;
        it.block_number = $urandom;
        it.rx_byte = card_byte();
        timed = (seq_phase == PH_TOKEN) || (seq_phase == PH_CMD &&
                (frame_cmd() == CMD_SD_OP || frame_cmd() == CMD_SEND_OP));
        if (timed && $urandom_range(0, 6) == 0) it.operation = OP_TICK;
        if ($urandom_range(0, 99) < 2) it = in_item_t'(42'({$urandom, $urandom}));
        return it;
    endfunction

    task automatic run_to_idle(input int cap);
        int n;
        n = 0;
        while (seq_phase != PH_IDLE && n < cap)
        begin
            send_item(card_item());
            n++;
        end
    endtask

    task automatic run_session();
        in_item_t it;
        profile = card_profile_t'($urandom_range(0, 5));
        sessions++;
        it = '0;
        it.operation = OP_INIT;
        it.block_number = $urandom;
        it.rx_byte = $urandom;
        send_item(it);
        run_to_idle(400);
        repeat ($urandom_range(1, 3))
        begin
            it.operation = OP_READ;
            it.block_number = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095);
            it.rx_byte = $urandom;
            send_item(it);
            run_to_idle($urandom_range(0, 3) == 0 ? 600 : 60);
        end
    endtask

    task automatic test_directed();
        in_item_t it;
        logic [1:0] ops[20] = '{OP_BYTE, OP_TICK, OP_READ, OP_BYTE, OP_BYTE, OP_BYTE,
                                OP_BYTE, OP_BYTE, OP_BYTE, OP_READ, OP_BYTE, OP_INIT,
                                OP_BYTE, OP_TICK, OP_BYTE, OP_READ, OP_INIT, OP_BYTE,
                                OP_BYTE, OP_TICK};
        logic [7:0] rxs[20] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F,
                                8'h01, 8'hFE, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00,
                                8'hFF, 8'h00, 8'h00, 8'h80, 8'h01, 8'h00};
        for (int i = 0; i < 20; i++)
        begin
            it.operation = ops[i];
            it.block_number = (i == 2) ? 32'hFFFF_FFFF : (i == 9 ? 32'h0 : 32'h0080_0001);
            it.rx_byte = rxs[i];
            send_item(it);
        end
        drain();
    endtask

    task automatic test_random(input int target);
        while (items_sent < target) run_session();
        drain();
    endtask

    task automatic test_backpressure();
        drain();
        hold_req = 1'b1;
        run_session();
        req_valid <= 1'b0;
        while (hold_req) @(posedge clk);
        drain();
    endtask

    initial
    begin
        cfg_m = {INIT_TIMEOUT_RST, TOKEN_TIMEOUT_RST, RESET_ATT_RST, READ_ATT_RST,
                 POLL_BYTES_RST};
        seq_phase = PH_IDLE;
        xfer_count = '0;
        try_count = '0;
        poll_seen = '0;
        cmd_frame = '0;
        ms_left = '0;
        reply_word = '0;
        last_r1 = 8'hFF;
        model_kind = KIND_UNKNOWN;
        read_addr = '0;
        fast_sel = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);
        set_config(16'd1, 16'd1, 4'd1, 4'd1, 4'd1);
        test_random(600);
        set_config(16'd3, 16'd2, 4'd0, 4'd0, 4'd0);
        test_random(850);
        set_config(16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 4'd15);
        test_backpressure();
        test_random(1150);
        repeat (3)
        begin
            set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 20)),
                       4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
                       4'($urandom_range(1, 15)));
            test_random(items_sent + 220);
        end
        test_backpressure();

        drain();
        repeat (10) @(posedge clk);
        if (expected_q.size() != 0)
            report_err($sformatf("%0d results never arrived", expected_q.size()));
        $display("covered %0d items, %0d results, %0d card sessions, %0d register settings",
                 items_sent, results_seen, sessions, cfg_sets);
        if (errors == 0)
            $display("sd_card_spi_host_sequencer regression: pass");
        else
            $display("sd_card_spi_host_sequencer regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("sd_card_spi_host_sequencer regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/sdsh_pkg.sv
sv/sdsh_cfg.sv
sv/sdsh_core.sv
sv/sd_card_spi_host_sequencer.sv
tb/sd_card_spi_host_sequencer_tb.sv
